>>> rtl/yaml_plain_scalar_type_detector_core_assert.svh
// Assertion macros used by the detector core
`ifndef YAML_PLAIN_SCALAR_TYPE_DETECTOR_CORE_ASSERT_SVH
`define YAML_PLAIN_SCALAR_TYPE_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication
`define YAMLST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define YAMLST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/yamlst_pkg.sv
package yamlst_pkg;

  localparam int NP = 51;
  localparam int KW_N = 131;
  localparam int KW_WORDS = 40;

  localparam int P_START = 0;
  localparam int P_SIGN  = 1;
  localparam int P_Z0    = 2;
  localparam int P_BB    = 3;
  localparam int P_BD    = 4;
  localparam int P_OO    = 5;
  localparam int P_OD    = 6;
  localparam int P_XX    = 7;
  localparam int P_XD    = 8;
  localparam int P_DI    = 9;
  localparam int P_SI1   = 10;
  localparam int P_SC    = 11;
  localparam int P_SA    = 12;
  localparam int P_SB    = 13;
  localparam int P_FP    = 14;
  localparam int P_FE    = 15;
  localparam int P_FES   = 16;
  localparam int P_FX    = 17;
  localparam int P_XC    = 18;
  localparam int P_XA    = 19;
  localparam int P_XB    = 20;
  localparam int P_XF    = 21;
  localparam int P_T1    = 22;
  localparam int P_T2    = 23;
  localparam int P_T3    = 24;
  localparam int P_T4    = 25;
  localparam int P_TM1   = 26;
  localparam int P_TMA   = 27;
  localparam int P_TMB   = 28;
  localparam int P_TD0   = 29;
  localparam int P_TDA   = 30;
  localparam int P_TDB   = 31;
  localparam int P_TT    = 32;
  localparam int P_TW    = 33;
  localparam int P_H1    = 34;
  localparam int P_H2    = 35;
  localparam int P_MI0   = 36;
  localparam int P_MI1   = 37;
  localparam int P_MI2   = 38;
  localparam int P_SE0   = 39;
  localparam int P_SE1   = 40;
  localparam int P_SE2   = 41;
  localparam int P_FR    = 42;
  localparam int P_ZW    = 43;
  localparam int P_ZZ    = 44;
  localparam int P_ZS    = 45;
  localparam int P_ZH1   = 46;
  localparam int P_ZH2   = 47;
  localparam int P_ZC    = 48;
  localparam int P_ZM1   = 49;
  localparam int P_ZM2   = 50;

  localparam logic [7:0] CH_COLON = 8'h3A;

  // Literal words, concatenated; first character sits in the top byte
  localparam logic [KW_N*8-1:0] KW_STR =
    {"~nullNullNULL", "yYyesYesYESnNnoNoNO", "trueTrueTRUEfalseFalseFALSE",
     "onOnONoffOffOFF", ".inf.Inf.INF+.inf+.Inf+.INF-.inf-.Inf-.INF",
     ".nan.NaN.NAN<<="};

  localparam int KW_LEN [KW_WORDS] = '{
    1, 4, 4, 4, 1, 1, 3, 3, 3, 1, 1, 2, 2, 2, 4, 4, 4, 5, 5, 5,
    2, 2, 2, 3, 3, 3, 4, 4, 4, 5, 5, 5, 5, 5, 5, 4, 4, 4, 2, 1};

  function automatic logic [KW_N-1:0] kw_first_mask();
    logic [KW_N-1:0] m;
    int pos;
    m = '0;
    pos = 0;
    for (int k = 0; k < KW_WORDS; k++) begin
      m[pos] = 1'b1;
      pos = pos + KW_LEN[k];
    end
    return m;
  endfunction

  function automatic logic [KW_N-1:0] kw_last_mask();
    logic [KW_N-1:0] m;
    int pos;
    m = '0;
    pos = 0;
    for (int k = 0; k < KW_WORDS; k++) begin
      pos = pos + KW_LEN[k];
      m[pos-1] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [KW_N-1:0] KW_FIRST = kw_first_mask();
  localparam logic [KW_N-1:0] KW_LAST  = kw_last_mask();

  typedef struct packed {
    logic [KW_N-1:0] kw;
    logic [NP-1:0]   pos;
  } nfa_state_t;

  localparam nfa_state_t NFA_RESET = '{kw: '0, pos: NP'(1) << P_START};

endpackage

>>> rtl/yamlst_in_if.sv
interface yamlst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;
  logic       is_empty;

  modport source(output valid, output char_byte, output is_last, output is_empty,
                 input ready);
  modport sink(input valid, input char_byte, input is_last, input is_empty,
               output ready);
endinterface

>>> rtl/yamlst_out_if.sv
interface yamlst_out_if;
  logic valid;
  logic ready;
  logic changes_type;

  modport source(output valid, output changes_type, input ready);
  modport sink(input valid, input changes_type, output ready);
endinterface

>>> rtl/yamlst_nfa.sv
module yamlst_nfa (
  input  yamlst_pkg::nfa_state_t cur,
  input  logic [7:0]             c,
  output yamlst_pkg::nfa_state_t nx,
  output logic                   acc
);
  import yamlst_pkg::*;

  logic dig, dig_u, blank, sign, hex_u, d15, d05, ee, pre;
  logic [KW_N-1:0] kw_nx;
  logic [NP-1:0]   p;
  logic [NP-1:0]   n;

  assign dig   = (c >= "0") && (c <= "9");
  assign dig_u = dig || (c == "_");
  assign blank = (c == " ") || (c == 8'h09);
  assign sign  = (c == "+") || (c == "-");
  assign hex_u = dig_u || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  assign d15   = (c >= "1") && (c <= "9");
  assign d05   = (c >= "0") && (c <= "5");
  assign ee    = (c == "e") || (c == "E");
  assign p     = cur.pos;
  assign pre   = p[P_START] || p[P_SIGN];

  always_comb begin
    n = '0;
    n[P_SIGN] = p[P_START] && sign;
    n[P_Z0]   = pre && (c == "0");
    n[P_SI1]  = (pre && d15) || (p[P_SI1] && dig_u);
    n[P_DI]   = (pre && dig) || (p[P_DI] && dig_u);
    n[P_FP]   = ((pre || p[P_DI]) && (c == ".")) || (p[P_FP] && dig_u);
    n[P_BB]   = p[P_Z0] && (c == "b");
    n[P_OO]   = p[P_Z0] && (c == "o");
    n[P_XX]   = p[P_Z0] && (c == "x");
    n[P_BD]   = (p[P_BB] || p[P_BD]) && ((c == "0") || (c == "1") || (c == "_"));
    n[P_OD]   = (p[P_OO] || p[P_OD]) && (c >= "0") && (c <= "7");
    n[P_XD]   = (p[P_XX] || p[P_XD]) && hex_u;
    n[P_FE]   = (p[P_DI] || p[P_FP]) && ee;
    n[P_XC]   = (p[P_DI] && (c == ":")) || (p[P_XB] && (c == ":"));
    n[P_SC]   = (p[P_SI1] || p[P_SB]) && (c == ":");
    n[P_SA]   = p[P_SC] && d05;
    n[P_SB]   = (p[P_SC] || p[P_SA]) && dig;
    n[P_FES]  = p[P_FE] && sign;
    n[P_FX]   = (p[P_FE] || p[P_FES] || p[P_FX]) && dig;
    n[P_XA]   = p[P_XC] && d05;
    n[P_XB]   = (p[P_XC] || p[P_XA]) && dig;
    n[P_XF]   = (p[P_XB] && (c == ".")) || (p[P_XF] && dig_u);
    // timestamp
    n[P_T1]   = p[P_START] && dig;
    n[P_T2]   = p[P_T1] && dig;
    n[P_T3]   = p[P_T2] && dig;
    n[P_T4]   = p[P_T3] && dig;
    n[P_TM1]  = p[P_T4] && (c == "-");
    n[P_TMA]  = p[P_TM1] && dig;
    n[P_TMB]  = p[P_TMA] && dig;
    n[P_TD0]  = (p[P_TMA] || p[P_TMB]) && (c == "-");
    n[P_TDA]  = p[P_TD0] && dig;
    n[P_TDB]  = p[P_TDA] && dig;
    n[P_TT]   = (p[P_TDA] || p[P_TDB]) && ((c == "T") || (c == "t"));
    n[P_TW]   = (p[P_TDA] || p[P_TDB] || p[P_TW]) && blank;
    n[P_H1]   = (p[P_TT] || p[P_TW]) && dig;
    n[P_H2]   = p[P_H1] && dig;
    n[P_MI0]  = (p[P_H1] || p[P_H2]) && (c == ":");
    n[P_MI1]  = p[P_MI0] && dig;
    n[P_MI2]  = p[P_MI1] && dig;
    n[P_SE0]  = p[P_MI2] && (c == ":");
    n[P_SE1]  = p[P_SE0] && dig;
    n[P_SE2]  = p[P_SE1] && dig;
    n[P_FR]   = (p[P_SE2] && (c == ".")) || (p[P_FR] && dig);
    n[P_ZW]   = (p[P_SE2] || p[P_FR] || p[P_ZW]) && blank;
    n[P_ZZ]   = (p[P_SE2] || p[P_FR] || p[P_ZW]) && (c == "Z");
    n[P_ZS]   = (p[P_SE2] || p[P_FR] || p[P_ZW]) && sign;
    n[P_ZH1]  = p[P_ZS] && dig;
    n[P_ZH2]  = p[P_ZH1] && dig;
    n[P_ZC]   = (p[P_ZH1] || p[P_ZH2]) && (c == ":");
    n[P_ZM1]  = p[P_ZC] && dig;
    n[P_ZM2]  = p[P_ZM1] && dig;
  end

  for (genvar i = 0; i < KW_N; i++) begin : g_kw
    logic prev;
    if (i == 0) begin : g_head
      assign prev = p[P_START];
    end else begin : g_body
      assign prev = KW_FIRST[i] ? p[P_START] : cur.kw[i-1];
    end
    assign kw_nx[i] = prev && (c == KW_STR[(KW_N-1-i)*8 +: 8]);
  end

  assign nx.pos = n;
  assign nx.kw  = kw_nx;

  assign acc = (|(kw_nx & KW_LAST)) || n[P_BD] || n[P_OD] || n[P_XD] || n[P_DI]
             || n[P_SB] || n[P_FP] || n[P_FX] || n[P_XF] || n[P_TDA] || n[P_TDB]
             || n[P_SE2] || n[P_FR] || n[P_ZZ] || n[P_ZH1] || n[P_ZH2] || n[P_ZM2];

endmodule

>>> rtl/yaml_plain_scalar_type_detector_core.sv
// Plain-scalar type detector. Takes one byte of a scalar string per cycle and,
// on the last byte (or an empty-string request), gives one result: 1 when the
// string written unquoted would resolve to null, bool, int, float, timestamp,
// merge key or '=' (or is empty, or starts with a colon). A new byte is taken
// every cycle; the result appears on the output register in the cycle after
// its last byte, set by the automaton step over the position set.
// While a result waits on a stalled output, no byte is taken until it leaves.
module yaml_plain_scalar_type_detector_core (
  input  logic         clk,
  input  logic         rst_n,
  yamlst_in_if.sink    in_chan,
  yamlst_out_if.source out_chan
);
  import yamlst_pkg::*;

  nfa_state_t state_r, state_nxt, step_nx;
  logic       first_r, first_nxt;
  logic       colon_r, colon_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_data_r, out_data_nxt;
  logic       step_acc;
  logic       in_fire;
  logic       colon_now;

  yamlst_nfa u_nfa (
    .cur (state_r),
    .c   (in_chan.char_byte),
    .nx  (step_nx),
    .acc (step_acc)
  );

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign colon_now     = colon_r || (first_r && (in_chan.char_byte == CH_COLON));

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    colon_nxt     = colon_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (in_fire) begin
      priority if (in_chan.is_empty) begin
        state_nxt     = NFA_RESET;
        first_nxt     = 1'b1;
        colon_nxt     = 1'b0;
        out_valid_nxt = 1'b1;
        out_data_nxt  = 1'b1;
      end else if (in_chan.is_last) begin
        state_nxt     = NFA_RESET;
        first_nxt     = 1'b1;
        colon_nxt     = 1'b0;
        out_valid_nxt = 1'b1;
        out_data_nxt  = colon_now || step_acc;
      end else begin
        state_nxt = step_nx;
        first_nxt = 1'b0;
        colon_nxt = colon_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= NFA_RESET;
      first_r     <= 1'b1;
      colon_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      colon_r     <= colon_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.changes_type = out_data_r;

`include "yaml_plain_scalar_type_detector_core_assert.svh"

  `YAMLST_ASSERT_NEXT(a_empty_gives_one, in_fire && in_chan.is_empty, out_valid_r && out_data_r, "empty request must give a 1 result")
  `YAMLST_ASSERT_NEXT(a_end_resets, in_fire && (in_chan.is_empty || in_chan.is_last), first_r && !colon_r && (state_r == NFA_RESET), "state not back to start after a result")
  `YAMLST_ASSERT_NOW(a_stall_blocks_input, out_valid_r && !out_chan.ready, !in_chan.ready, "input taken while a result is stalled")
  `YAMLST_ASSERT_NEXT(a_mid_no_result, in_fire && !in_chan.is_empty && !in_chan.is_last && !out_valid_r, !out_valid_r, "result raised on a middle byte")

endmodule

>>> tb/tb_yaml_plain_scalar_type_detector_core.sv
module tb_yaml_plain_scalar_type_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  import yamlst_pkg::*;

  localparam int KW_OFS      = 64;
  localparam int QUIET_LIMIT = 4000;
  localparam string DIG      = "0123456789";
  localparam string DIG_U    = "0123456789_";
  localparam string BLANKS   = " \t";
  localparam string MUT_CH   = "0123456789.:-+_eExXoObTtZ aAfnN\t";
  localparam string JUMBLE   = "0123456789+-.:_eEbxoTtZ \tyYnN<=~";

  logic clk;
  logic rst_n;

  yamlst_in_if  in_chan();
  yamlst_out_if out_chan();

  yaml_plain_scalar_type_detector_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  string kw_list [40] = '{
    "~", "null", "Null", "NULL",
    "y", "Y", "yes", "Yes", "YES", "n", "N", "no", "No", "NO",
    "true", "True", "TRUE", "false", "False", "FALSE",
    "on", "On", "ON", "off", "Off", "OFF",
    ".inf", ".Inf", ".INF", "+.inf", "+.Inf", "+.INF", "-.inf", "-.Inf", "-.INF",
    ".nan", ".NaN", ".NAN", "<<", "="};

  // predictor state
  bit [255:0] nfa_set;
  bit         await_first;
  bit         colon_first;

  bit changes_due [$];
  int mismatches;
  int quiet;
  bit moved;
  int sent_items;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_len;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit is_digit(input bit [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_digit_us(input bit [7:0] c);
    return is_digit(c) || c == "_";
  endfunction

  function automatic bit is_blank(input bit [7:0] c);
    return c == " " || c == 8'h09;
  endfunction

  function automatic bit is_pm(input bit [7:0] c);
    return c == "+" || c == "-";
  endfunction

  function automatic bit is_hex_us(input bit [7:0] c);
    return is_digit_us(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic void clear_scan();
    nfa_set = '0;
    nfa_set[P_START] = 1'b1;
    await_first = 1'b1;
    colon_first = 1'b0;
  endfunction

  // one transition over the whole position set; returns whether it now accepts
  function automatic bit nfa_step(input bit [7:0] c);
    bit [255:0] cur;
    bit [255:0] nx;
    bit acc;
    bit pre;
    bit prev;
    int base;
    int k;
    int p;
    string w;
    cur = nfa_set;
    nx = '0;
    acc = 1'b0;
    base = KW_OFS;
    pre = cur[P_START] || cur[P_SIGN];
    if (cur[P_START] && is_pm(c)) nx[P_SIGN] = 1'b1;
    if (pre) begin
      if (c == "0") nx[P_Z0] = 1'b1;
      if (is_digit(c)) nx[P_DI] = 1'b1;
      if (c >= "1" && c <= "9") nx[P_SI1] = 1'b1;
      if (c == ".") nx[P_FP] = 1'b1;
    end
    if (cur[P_Z0]) begin
      if (c == "b") nx[P_BB] = 1'b1;
      if (c == "o") nx[P_OO] = 1'b1;
      if (c == "x") nx[P_XX] = 1'b1;
    end
    if ((cur[P_BB] || cur[P_BD]) && (c == "0" || c == "1" || c == "_")) nx[P_BD] = 1'b1;
    if ((cur[P_OO] || cur[P_OD]) && c >= "0" && c <= "7") nx[P_OD] = 1'b1;
    if ((cur[P_XX] || cur[P_XD]) && is_hex_us(c)) nx[P_XD] = 1'b1;
    if (cur[P_DI]) begin
      if (is_digit_us(c)) nx[P_DI] = 1'b1;
      if (c == ".") nx[P_FP] = 1'b1;
      if (c == "e" || c == "E") nx[P_FE] = 1'b1;
      if (c == ":") nx[P_XC] = 1'b1;
    end
    if (cur[P_SI1]) begin
      if (is_digit_us(c)) nx[P_SI1] = 1'b1;
      if (c == ":") nx[P_SC] = 1'b1;
    end
    if (cur[P_SC]) begin
      if (is_digit(c)) nx[P_SB] = 1'b1;
      if (c >= "0" && c <= "5") nx[P_SA] = 1'b1;
    end
    if (cur[P_SA] && is_digit(c)) nx[P_SB] = 1'b1;
    if (cur[P_SB] && c == ":") nx[P_SC] = 1'b1;
    if (cur[P_FP]) begin
      if (is_digit_us(c)) nx[P_FP] = 1'b1;
      if (c == "e" || c == "E") nx[P_FE] = 1'b1;
    end
    if (cur[P_FE]) begin
      if (is_pm(c)) nx[P_FES] = 1'b1;
      if (is_digit(c)) nx[P_FX] = 1'b1;
    end
    if ((cur[P_FES] || cur[P_FX]) && is_digit(c)) nx[P_FX] = 1'b1;
    if (cur[P_XC]) begin
      if (is_digit(c)) nx[P_XB] = 1'b1;
      if (c >= "0" && c <= "5") nx[P_XA] = 1'b1;
    end
    if (cur[P_XA] && is_digit(c)) nx[P_XB] = 1'b1;
    if (cur[P_XB]) begin
      if (c == ":") nx[P_XC] = 1'b1;
      if (c == ".") nx[P_XF] = 1'b1;
    end
    if (cur[P_XF] && is_digit_us(c)) nx[P_XF] = 1'b1;

    // timestamp
    if (is_digit(c)) begin
      if (cur[P_START]) nx[P_T1] = 1'b1;
      if (cur[P_T1]) nx[P_T2] = 1'b1;
      if (cur[P_T2]) nx[P_T3] = 1'b1;
      if (cur[P_T3]) nx[P_T4] = 1'b1;
      if (cur[P_TM1]) nx[P_TMA] = 1'b1;
      if (cur[P_TMA]) nx[P_TMB] = 1'b1;
      if (cur[P_TD0]) nx[P_TDA] = 1'b1;
      if (cur[P_TDA]) nx[P_TDB] = 1'b1;
      if (cur[P_TT] || cur[P_TW]) nx[P_H1] = 1'b1;
      if (cur[P_H1]) nx[P_H2] = 1'b1;
      if (cur[P_MI0]) nx[P_MI1] = 1'b1;
      if (cur[P_MI1]) nx[P_MI2] = 1'b1;
      if (cur[P_SE0]) nx[P_SE1] = 1'b1;
      if (cur[P_SE1]) nx[P_SE2] = 1'b1;
      if (cur[P_FR]) nx[P_FR] = 1'b1;
      if (cur[P_ZS]) nx[P_ZH1] = 1'b1;
      if (cur[P_ZH1]) nx[P_ZH2] = 1'b1;
      if (cur[P_ZC]) nx[P_ZM1] = 1'b1;
      if (cur[P_ZM1]) nx[P_ZM2] = 1'b1;
    end
    if (c == "-") begin
      if (cur[P_T4]) nx[P_TM1] = 1'b1;
      if (cur[P_TMA] || cur[P_TMB]) nx[P_TD0] = 1'b1;
    end
    if (cur[P_TDA] || cur[P_TDB]) begin
      if (c == "T" || c == "t") nx[P_TT] = 1'b1;
      if (is_blank(c)) nx[P_TW] = 1'b1;
    end
    if (cur[P_TW] && is_blank(c)) nx[P_TW] = 1'b1;
    if (c == ":") begin
      if (cur[P_H1] || cur[P_H2]) nx[P_MI0] = 1'b1;
      if (cur[P_MI2]) nx[P_SE0] = 1'b1;
      if (cur[P_ZH1] || cur[P_ZH2]) nx[P_ZC] = 1'b1;
    end
    if (cur[P_SE2] && c == ".") nx[P_FR] = 1'b1;
    if (cur[P_SE2] || cur[P_FR] || cur[P_ZW]) begin
      if (is_blank(c)) nx[P_ZW] = 1'b1;
      if (c == "Z") nx[P_ZZ] = 1'b1;
      if (is_pm(c)) nx[P_ZS] = 1'b1;
    end

    // literal words, one position per character
    for (k = 0; k < 40; k++) begin
      w = kw_list[k];
      for (p = 0; p < w.len(); p++) begin
        if (p == 0) prev = cur[P_START];
        else prev = cur[base + p - 1];
        if (prev && c == w[p]) nx[base + p] = 1'b1;
      end
      if (nx[base + w.len() - 1]) acc = 1'b1;
      base = base + w.len();
    end

    acc = acc || nx[P_BD] || nx[P_OD] || nx[P_XD] || nx[P_DI] || nx[P_SB] || nx[P_FP]
        || nx[P_FX] || nx[P_XF] || nx[P_TDA] || nx[P_TDB] || nx[P_SE2] || nx[P_FR]
        || nx[P_ZZ] || nx[P_ZH1] || nx[P_ZH2] || nx[P_ZM2];
    nfa_set = nx;
    return acc;
  endfunction

  function automatic void resolve_request(input bit [7:0] c, input bit last, input bit empty);
    bit acc;
    if (empty) begin
      clear_scan();
      changes_due = {changes_due, 1'b1};
      return;
    end
    if (await_first && c == CH_COLON) colon_first = 1'b1;
    await_first = 1'b0;
    acc = nfa_step(c);
    if (last) begin
      changes_due = {changes_due, bit'(colon_first || acc)};
      clear_scan();
    end
  endfunction

  // request monitor, result checker and watchdog in one process so that the
  // prediction of a request always lands before a result in the same cycle
  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (in_chan.valid && in_chan.ready) begin
        resolve_request(in_chan.char_byte, in_chan.is_last, in_chan.is_empty);
        moved = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        moved = 1'b1;
        if (changes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result changes_type=%0b", $realtime,
                     out_chan.changes_type);
        end else if (changes_due[0] !== out_chan.changes_type) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: changes_type expected %0b got %0b", $realtime,
                     changes_due[0], out_chan.changes_type);
          void'(changes_due.pop_front());
        end else begin
          void'(changes_due.pop_front());
        end
      end
      if (moved) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_chan.ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      out_chan.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // entered and left at a falling edge; valid stays high after acceptance
  task automatic send_request(input bit [7:0] c, input bit last, input bit empty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.char_byte = c;
    in_chan.is_last = last;
    in_chan.is_empty = empty;
    do @(posedge clk); while (!in_chan.ready);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_empty();
    send_request(8'($urandom), 1'($urandom), 1'b1);
  endtask

  task automatic send_scalar(input string s);
    int i;
    if (s.len() == 0) send_empty();
    for (i = 0; i < s.len(); i++) send_request(s[i], i == s.len() - 1, 1'b0);
  endtask

  task automatic wait_drain();
    in_chan.valid = 1'b0;
    while (changes_due.size() != 0) @(negedge clk);
  endtask

  function automatic string pick_from(input string alpha, input int lo, input int hi);
    string s;
    int n;
    int i;
    int k;
    s = "";
    n = $urandom_range(hi, lo);
    for (i = 0; i < n; i++) begin
      k = $urandom_range(alpha.len() - 1);
      s = {s, alpha.substr(k, k)};
    end
    return s;
  endfunction

  function automatic string sexa_tail();
    string s;
    int n;
    int i;
    s = "";
    n = $urandom_range(3, 1);
    for (i = 0; i < n; i++) s = {s, ":", pick_from("012345", 0, 1), pick_from(DIG, 1, 1)};
    return s;
  endfunction

  function automatic string make_stamp();
    string s;
    s = {pick_from(DIG, 4, 4), "-", pick_from(DIG, 1, 2), "-", pick_from(DIG, 1, 2)};
    if ($urandom_range(3) != 0) begin
      if ($urandom_range(1)) s = {s, pick_from("Tt", 1, 1)};
      else s = {s, pick_from(BLANKS, 1, 3)};
      s = {s, pick_from(DIG, 1, 2), ":", pick_from(DIG, 2, 2), ":", pick_from(DIG, 2, 2)};
      if ($urandom_range(1)) s = {s, ".", pick_from(DIG, 0, 3)};
      if ($urandom_range(1)) begin
        s = {s, pick_from(BLANKS, 0, 2)};
        if ($urandom_range(1)) s = {s, "Z"};
        else begin
          s = {s, pick_from("+-", 1, 1), pick_from(DIG, 1, 2)};
          if ($urandom_range(1)) s = {s, ":", pick_from(DIG, 2, 2)};
        end
      end
    end
    return s;
  endfunction

  function automatic string make_scalar();
    string s;
    string pm;
    int p;
    pm = pick_from("+-", 0, 1);
    case ($urandom_range(11))
      0: s = kw_list[$urandom_range(39)];
      1: s = {pm, "0b", pick_from("01_", 1, 6)};
      2: s = {pm, "0o", pick_from("01234567", 1, 5)};
      3: s = {pm, "0x", pick_from("0123456789abcdefABCDEF_", 1, 6)};
      4: s = {pm, pick_from(DIG, 1, 1), pick_from(DIG_U, 0, 6)};
      5: s = {pm, pick_from("123456789", 1, 1), pick_from(DIG_U, 0, 3), sexa_tail()};
      6: begin
        s = pm;
        if ($urandom_range(1)) s = {s, pick_from(DIG, 1, 1), pick_from(DIG_U, 0, 3)};
        s = {s, ".", pick_from(DIG_U, 0, 4)};
        if ($urandom_range(1))
          s = {s, pick_from("eE", 1, 1), pick_from("+-", 0, 1), pick_from(DIG, 1, 3)};
      end
      7: s = {pm, pick_from(DIG, 1, 1), pick_from(DIG_U, 0, 3), pick_from("eE", 1, 1),
              pick_from("+-", 0, 1), pick_from(DIG, 1, 3)};
      8: s = {pm, pick_from(DIG, 1, 1), pick_from(DIG_U, 0, 2), sexa_tail(), ".",
              pick_from(DIG_U, 0, 3)};
      9: begin
        if ($urandom_range(1)) s = {pm, ".", pick_from("iI", 1, 1), pick_from("nN", 1, 1),
                                    pick_from("fF", 1, 1)};
        else s = {pm, ".", pick_from("nN", 1, 1), pick_from("aA", 1, 1),
                  pick_from("nN", 1, 1)};
      end
      10: s = make_stamp();
      default: s = pick_from(JUMBLE, 1, 8);
    endcase
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(2))
        0: begin
          if (s.len() > 0) begin
            p = $urandom_range(s.len() - 1);
            s[p] = MUT_CH[$urandom_range(MUT_CH.len() - 1)];
          end
        end
        1: if (s.len() > 0) s = s.substr(0, s.len() - 2);
        default: s = {s, pick_from(MUT_CH, 1, 1)};
      endcase
    end
    return s;
  endfunction

  task automatic send_random_scalar();
    string s;
    int r;
    int i;
    r = $urandom_range(99);
    if (r < 6) begin
      // raw bytes over the full range, NUL and non-ASCII included
      r = $urandom_range(6, 1);
      for (i = 0; i < r; i++) send_request(8'($urandom), i == r - 1, 1'b0);
    end else if (r < 11) begin
      // string cut short by an empty request
      s = make_scalar();
      for (i = 0; i + 1 < s.len(); i++) send_request(s[i], 1'b0, 1'b0);
      send_empty();
    end else if (r < 14) begin
      send_empty();
    end else begin
      send_scalar(make_scalar());
    end
  endtask

  task automatic test_directed();
    send_scalar("");
    send_scalar(":x");
    send_scalar("~");
    send_scalar("y");
    send_scalar("0x_F");
    send_scalar("1:5");
    send_scalar(".5e3");
    send_scalar("=");
    send_scalar("<<");
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(CH_COLON, 1'b0, 1'b0);
    send_empty();
    send_scalar("ab");
  endtask

  task automatic test_random_scalars(input int n);
    int goal;
    goal = sent_items + n;
    while (sent_items < goal) send_random_scalar();
  endtask

  task automatic test_output_stall();
    int i;
    hold_len = 400;
    for (i = 0; i < 30; i++) send_random_scalar();
  endtask

  task automatic test_pause_drain();
    int i;
    for (i = 0; i < 10; i++) send_random_scalar();
    wait_drain();
    for (i = 0; i < 10; i++) send_random_scalar();
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.char_byte = 8'h00;
    in_chan.is_last = 1'b0;
    in_chan.is_empty = 1'b0;
    mismatches = 0;
    quiet = 0;
    sent_items = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 0;
    clear_scan();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 56;
    test_directed();
    test_random_scalars(220);
    test_output_stall();

    send_idle_pct = 56;
    recv_idle_pct = 34;
    test_random_scalars(220);
    test_pause_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_scalars(220);

    wait_drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && changes_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> yaml_plain_scalar_type_detector_core.f
+incdir+rtl
rtl/yamlst_pkg.sv
rtl/yamlst_in_if.sv
rtl/yamlst_out_if.sv
rtl/yamlst_nfa.sv
rtl/yaml_plain_scalar_type_detector_core.sv
tb/tb_yaml_plain_scalar_type_detector_core.sv
